/* rtl/swdc_pkg.sv */
package swdc_pkg;

    // marker ids and hit counters
    localparam int NUM_IDS       = 64;
    localparam int ID_W          = $clog2(NUM_IDS);
    localparam int CNT_W         = 9;
    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // frame ring
    localparam int MAX_WINDOW    = 32;
    localparam int SLOT_W        = $clog2(MAX_WINDOW);
    localparam int HELD_W        = SLOT_W + 1;
    localparam int MAX_PER_FRAME = 16;
    localparam int ENTRY_W       = $clog2(MAX_PER_FRAME);
    localparam int FILL_W        = ENTRY_W + 1;
    localparam int STORE_W       = SLOT_W + ENTRY_W;

    // configuration registers
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 9;
    localparam int WIN_W         = 6;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
    localparam logic [WIN_W-1:0] WINDOW_RESET    = 6'd30;
    localparam logic [CNT_W-1:0] THRESHOLD_RESET = 9'd25;

    // sequencer states
    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_EV_CHK  = 8'b0000_0010,
        S_EV_FILL = 8'b0000_0100,
        S_EV_ID   = 8'b0000_1000,
        S_EV_DEC  = 8'b0001_0000,
        S_OPEN    = 8'b0010_0000,
        S_DET     = 8'b0100_0000,
        S_CNT_WR  = 8'b1000_0000
    } state_t;

endpackage

/* rtl/sliding_window_detection_confirm.sv */
// Confirms marker detections that persist over the last window_frames video frames.
// A detection that does not start a frame is taken in the idle state, which starts
// its hit counter read; the result is registered, and the counter written back
// unless the detection is dropped, once the output register is free. An item with
// frame_start, or a detection while no frame is held, first retires the frames
// beyond the window, opens a new frame and then counts its detection if it carries
// one; the eviction walk reads one stored id and one counter per entry. Counters
// read as zero after reset through per-id valid bits, so there is no clearing pass.
// A result waits in the output register while the next beat is taken; the block
// stalls only when a new result is ready and the previous one has not been taken.
module sliding_window_detection_confirm
    import swdc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // configuration
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    // input beats
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [ID_W-1:0]       marker_id,
    input  logic                  has_marker,
    input  logic                  frame_start,
    // result beats
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [ID_W-1:0]       out_marker_id,
    output logic [CNT_W-1:0]      hit_count,
    output logic                  confirmed,
    output logic                  dropped
);

    // control registers
    state_t             state_reg, state_next;
    logic [HELD_W-1:0]  held_reg, held_next;
    logic [SLOT_W-1:0]  newest_reg, newest_next;
    logic [SLOT_W-1:0]  oldest_reg, oldest_next;
    logic [FILL_W-1:0]  cur_fill_reg, cur_fill_next;
    logic [FILL_W-1:0]  evict_n_reg, evict_n_next;
    logic [FILL_W-1:0]  evict_k_reg, evict_k_next;
    logic [WIN_W-1:0]   window_reg;
    logic [CNT_W-1:0]   thr_reg;
    logic [ID_W-1:0]    mid_reg, mid_next;
    logic               has_reg, has_next;
    logic               dropped_reg, dropped_next;
    logic               out_valid_reg;
    logic [NUM_IDS-1:0] cnt_valid_reg;
    logic               cnt_rd_vld_reg;

    // output payload
    logic [ID_W-1:0]    out_mid_reg;
    logic [CNT_W-1:0]   out_cnt_reg;
    logic               out_conf_reg;
    logic               out_drop_reg;

    // memories
    logic [CNT_W-1:0]   cnt_mem [NUM_IDS];
    logic [CNT_W-1:0]   cnt_rd_reg;
    logic [ID_W-1:0]    id_mem [MAX_WINDOW * MAX_PER_FRAME];
    logic [ID_W-1:0]    id_rd_reg;
    logic [FILL_W-1:0]  fill_mem [MAX_WINDOW];
    logic [FILL_W-1:0]  fill_rd_reg;

    // memory port controls
    logic               cnt_rd_en, cnt_we;
    logic [ID_W-1:0]    cnt_rd_addr, cnt_wr_addr;
    logic [CNT_W-1:0]   cnt_wr_data;
    logic               id_we, id_rd_en;
    logic [STORE_W-1:0] id_wr_addr, id_rd_addr;
    logic [ID_W-1:0]    id_wr_data;
    logic               fill_we, fill_rd_en;
    logic [SLOT_W-1:0]  fill_wr_addr, fill_rd_addr;
    logic [FILL_W-1:0]  fill_wr_data;

    // datapath helpers
    logic               det_go;
    logic [ID_W-1:0]    det_mid;
    logic               out_free, out_load;
    logic [HELD_W-1:0]  win_eff;
    logic [HELD_W-1:0]  held_m1;
    logic [SLOT_W-1:0]  oldest_calc;
    logic [SLOT_W-1:0]  open_slot;
    logic [FILL_W-1:0]  fill_clamp;
    logic [FILL_W-1:0]  k_inc;
    logic [CNT_W-1:0]   cnt_old, cnt_inc;
    logic               conf_new;

    // effective window, clamped to 1..MAX_WINDOW
    always_comb
    begin
        if (window_reg == '0)
            win_eff = HELD_W'(1);
        else if (HELD_W'(window_reg) > HELD_W'(MAX_WINDOW))
            win_eff = HELD_W'(MAX_WINDOW);
        else
            win_eff = HELD_W'(window_reg);
    end

    // ring position of the oldest held frame
    assign held_m1     = held_reg - HELD_W'(1);
    assign oldest_calc = newest_reg - held_m1[SLOT_W-1:0];
    assign open_slot   = (held_reg != '0) ? newest_reg + SLOT_W'(1) : newest_reg;
    assign fill_clamp  = (fill_rd_reg > FILL_W'(MAX_PER_FRAME)) ? FILL_W'(MAX_PER_FRAME)
                                                                : fill_rd_reg;
    assign k_inc       = evict_k_reg + FILL_W'(1);

    // counter value as read, zero where never written
    assign cnt_old  = cnt_rd_vld_reg ? cnt_rd_reg : '0;
    assign cnt_inc  = (cnt_old == COUNT_MAX) ? cnt_old : cnt_old + CNT_W'(1);
    assign conf_new = (cnt_inc > thr_reg);

    assign out_free = !out_valid_reg || out_ready;

    // sequencer
    always_comb
    begin
        state_next    = state_reg;
        held_next     = held_reg;
        newest_next   = newest_reg;
        oldest_next   = oldest_reg;
        cur_fill_next = cur_fill_reg;
        evict_n_next  = evict_n_reg;
        evict_k_next  = evict_k_reg;
        mid_next      = mid_reg;
        has_next      = has_reg;
        dropped_next  = dropped_reg;
        in_ready      = 1'b0;
        out_load      = 1'b0;
        det_go        = 1'b0;
        det_mid       = mid_reg;
        cnt_rd_en     = 1'b0;
        cnt_rd_addr   = mid_reg;
        cnt_we        = 1'b0;
        cnt_wr_addr   = mid_reg;
        cnt_wr_data   = cnt_inc;
        id_we         = 1'b0;
        id_rd_en      = 1'b0;
        id_rd_addr    = {oldest_reg, evict_k_reg[ENTRY_W-1:0]};
        fill_we       = 1'b0;
        fill_wr_addr  = newest_reg;
        fill_wr_data  = '0;
        fill_rd_en    = 1'b0;
        fill_rd_addr  = oldest_calc;

        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    mid_next = marker_id;
                    has_next = has_marker;
                    if (frame_start || (has_marker && held_reg == '0))
                        state_next = S_EV_CHK;
                    else if (has_marker)
                    begin
                        det_go     = 1'b1;
                        det_mid    = marker_id;
                        state_next = S_CNT_WR;
                    end
                end
            end
            S_EV_CHK:
            begin
                if (held_reg != '0 && held_reg >= win_eff)
                begin
                    oldest_next = oldest_calc;
                    fill_rd_en  = 1'b1;
                    state_next  = S_EV_FILL;
                end
                else
                    state_next = S_OPEN;
            end
            S_EV_FILL:
            begin
                evict_n_next = fill_clamp;
                evict_k_next = '0;
                if (fill_clamp == '0)
                begin
                    held_next  = held_m1;
                    state_next = S_EV_CHK;
                end
                else
                begin
                    id_rd_en   = 1'b1;
                    id_rd_addr = {oldest_reg, {ENTRY_W{1'b0}}};
                    state_next = S_EV_ID;
                end
            end
            S_EV_ID:
            begin
                cnt_rd_en   = 1'b1;
                cnt_rd_addr = id_rd_reg;
                state_next  = S_EV_DEC;
            end
            S_EV_DEC:
            begin
                if (cnt_old != '0)
                begin
                    cnt_we      = 1'b1;
                    cnt_wr_addr = id_rd_reg;
                    cnt_wr_data = cnt_old - CNT_W'(1);
                end
                evict_k_next = k_inc;
                if (k_inc == evict_n_reg)
                begin
                    held_next  = held_m1;
                    state_next = S_EV_CHK;
                end
                else
                begin
                    id_rd_en   = 1'b1;
                    id_rd_addr = {oldest_reg, k_inc[ENTRY_W-1:0]};
                    state_next = S_EV_ID;
                end
            end
            S_OPEN:
            begin
                newest_next   = open_slot;
                fill_we       = 1'b1;
                fill_wr_addr  = open_slot;
                fill_wr_data  = '0;
                cur_fill_next = '0;
                held_next     = held_reg + HELD_W'(1);
                state_next    = has_reg ? S_DET : S_IDLE;
            end
            S_DET:
            begin
                det_go     = 1'b1;
                det_mid    = mid_reg;
                state_next = S_CNT_WR;
            end
            S_CNT_WR:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    cnt_we     = !dropped_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // detection: store the id in the newest frame and fetch its counter
        if (det_go)
        begin
            cnt_rd_en   = 1'b1;
            cnt_rd_addr = det_mid;
            if (cur_fill_reg < FILL_W'(MAX_PER_FRAME))
            begin
                id_we         = 1'b1;
                fill_we       = 1'b1;
                fill_wr_addr  = newest_reg;
                fill_wr_data  = cur_fill_reg + FILL_W'(1);
                cur_fill_next = cur_fill_reg + FILL_W'(1);
                dropped_next  = 1'b0;
            end
            else
                dropped_next = 1'b1;
        end
    end

    assign id_wr_addr = {newest_reg, cur_fill_reg[ENTRY_W-1:0]};
    assign id_wr_data = det_mid;

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            held_reg       <= '0;
            newest_reg     <= '0;
            oldest_reg     <= '0;
            cur_fill_reg   <= '0;
            evict_n_reg    <= '0;
            evict_k_reg    <= '0;
            has_reg        <= 1'b0;
            dropped_reg    <= 1'b0;
            window_reg     <= WINDOW_RESET;
            thr_reg        <= THRESHOLD_RESET;
            out_valid_reg  <= 1'b0;
            cnt_valid_reg  <= '0;
            cnt_rd_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            held_reg     <= held_next;
            newest_reg   <= newest_next;
            oldest_reg   <= oldest_next;
            cur_fill_reg <= cur_fill_next;
            evict_n_reg  <= evict_n_next;
            evict_k_reg  <= evict_k_next;
            has_reg      <= has_next;
            dropped_reg  <= dropped_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_WINDOW:    window_reg <= cfg_data[WIN_W-1:0];
                    CFG_THRESHOLD: thr_reg    <= cfg_data[CNT_W-1:0];
                    default:       ;
                endcase
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            if (cnt_rd_en)
                cnt_rd_vld_reg <= cnt_valid_reg[cnt_rd_addr];
            if (cnt_we)
                cnt_valid_reg[cnt_wr_addr] <= 1'b1;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        mid_reg <= mid_next;
        if (out_load)
        begin
            out_mid_reg  <= mid_reg;
            out_cnt_reg  <= dropped_reg ? cnt_old : cnt_inc;
            out_conf_reg <= !dropped_reg && conf_new;
            out_drop_reg <= dropped_reg;
        end
    end

    // hit counter memory
    always_ff @(posedge clk)
    begin
        if (cnt_we)
            cnt_mem[cnt_wr_addr] <= cnt_wr_data;
        if (cnt_rd_en)
            cnt_rd_reg <= cnt_mem[cnt_rd_addr];
    end

    // frame id store
    always_ff @(posedge clk)
    begin
        if (id_we)
            id_mem[id_wr_addr] <= id_wr_data;
        if (id_rd_en)
            id_rd_reg <= id_mem[id_rd_addr];
    end

    // per-frame fill memory
    always_ff @(posedge clk)
    begin
        if (fill_we)
            fill_mem[fill_wr_addr] <= fill_wr_data;
        if (fill_rd_en)
            fill_rd_reg <= fill_mem[fill_rd_addr];
    end

    assign out_valid     = out_valid_reg;
    assign out_marker_id = out_mid_reg;
    assign hit_count     = out_cnt_reg;
    assign confirmed     = out_conf_reg;
    assign dropped       = out_drop_reg;

    // ring never holds more frames than it has slots
    assert property (@(posedge clk) disable iff (!rst_n)
        held_reg <= HELD_W'(MAX_WINDOW))
        else $error("frames held exceeds ring depth");

    // newest frame fill stays within capacity
    assert property (@(posedge clk) disable iff (!rst_n)
        cur_fill_reg <= FILL_W'(MAX_PER_FRAME))
        else $error("frame fill exceeds capacity");

    // a counted detection always reports a nonzero count
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !dropped) |-> (hit_count != '0))
        else $error("counted detection with zero hits");

    // a dropped detection is never confirmed
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && dropped) |-> !confirmed)
        else $error("dropped detection marked confirmed");

    // a detection is counted only with a frame held
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CNT_WR) |-> (held_reg != '0))
        else $error("detection counted with no frame held");

endmodule

/* sim/sliding_window_detection_confirm_tb.sv */
`timescale 1ns / 1ps

module sliding_window_detection_confirm_tb;
    import swdc_pkg::*;

    localparam int SETTLE_CYCLES = 1200;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam logic [ID_W-1:0] SAT_ID = 6'd21;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] count;
        logic             conf;
        logic             drop;
    } detection_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    logic [ID_W-1:0]       marker_id;
    logic                  has_marker;
    logic                  frame_start;
    logic                  out_valid;
    logic                  out_ready;
    logic [ID_W-1:0]       out_marker_id;
    logic [CNT_W-1:0]      hit_count;
    logic                  confirmed;
    logic                  dropped;

    // shadow of the block state
    logic [CNT_W-1:0] hits_q [NUM_IDS];
    logic [ID_W-1:0]  ids_q  [MAX_WINDOW*MAX_PER_FRAME];
    logic [FILL_W-1:0] fill_q [MAX_WINDOW];
    int               held;
    int               newest;
    logic [WIN_W-1:0] win_reg;
    logic [CNT_W-1:0] thr_reg;

    detection_result_t expected_hits[$];
    detection_result_t want;

    bit idle_on;
    bit stall_on;
    int failures;
    int beats_sent;
    int results_checked;
    int confirmed_seen;
    int dropped_seen;

    sliding_window_detection_confirm u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .marker_id     (marker_id),
        .has_marker    (has_marker),
        .frame_start   (frame_start),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_marker_id (out_marker_id),
        .hit_count     (hit_count),
        .confirmed     (confirmed),
        .dropped       (dropped)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // retire frames beyond the window, then open an empty newest frame
    function automatic void open_frame();
        int w;
        int oldest;
        int n;
        int k;
        logic [ID_W-1:0] id;
        w = (win_reg == 0) ? 1 : ((win_reg > MAX_WINDOW) ? MAX_WINDOW : int'(win_reg));
        while (held > 0 && held >= w)
        begin
            oldest = (newest + MAX_WINDOW - ((held - 1) % MAX_WINDOW)) % MAX_WINDOW;
            n = fill_q[oldest];
            if (n > MAX_PER_FRAME)
                n = MAX_PER_FRAME;
            for (k = 0; k < n; k++)
            begin
                id = ids_q[oldest*MAX_PER_FRAME + k];
                if (hits_q[id] != '0)
                    hits_q[id] = hits_q[id] - 1'b1;
            end
            held--;
        end
        if (held > 0)
            newest = (newest + 1) % MAX_WINDOW;
        fill_q[newest] = '0;
        held++;
    endfunction

    // expected hit result for one accepted beat
    function automatic void predict_hits(logic [ID_W-1:0] id, logic has, logic start);
        detection_result_t res;
        int fill;
        if (start)
            open_frame();
        if (!has)
            return;
        if (held == 0)
            open_frame();
        fill = fill_q[newest];
        res.id = id;
        if (fill >= MAX_PER_FRAME)
        begin
            res.count = hits_q[id];
            res.conf  = 1'b0;
            res.drop  = 1'b1;
        end
        else
        begin
            ids_q[newest*MAX_PER_FRAME + fill] = id;
            fill_q[newest] = FILL_W'(fill + 1);
            if (hits_q[id] != COUNT_MAX)
                hits_q[id] = hits_q[id] + 1'b1;
            res.count = hits_q[id];
            res.conf  = (hits_q[id] > thr_reg);
            res.drop  = 1'b0;
        end
        expected_hits = {expected_hits, res};
    endfunction

    // one input beat, called at a rising edge
    task automatic send_beat(input logic [ID_W-1:0] id, input logic has, input logic start);
        int gap;
        gap = idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        marker_id   <= id;
        has_marker  <= has;
        frame_start <= start;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_hits(id, has, start);
        beats_sent++;
    endtask

    // wait for all results, then let any eviction walk finish
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register write, block idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_WINDOW:    win_reg = val[WIN_W-1:0];
            CFG_THRESHOLD: thr_reg = val[CNT_W-1:0];
            default: ;
        endcase
    endtask

    // detections right after reset open a frame on their own
    task automatic test_before_first_frame();
        send_beat(6'd5, 1'b1, 1'b0);
        send_beat(6'd63, 1'b1, 1'b0);
        send_beat(6'd0, 1'b1, 1'b0);
    endtask

    // beats that carry no detection give no result
    task automatic test_idle_items();
        send_beat(6'd17, 1'b0, 1'b0);
        send_beat(6'd42, 1'b0, 1'b0);
        send_beat(6'd0, 1'b0, 1'b1);
        send_beat(6'd63, 1'b0, 1'b1);
    endtask

    // seventeenth detection of a frame overflows its capacity
    task automatic test_frame_full();
        int e;
        send_beat(6'd9, 1'b1, 1'b1);
        for (e = 0; e < MAX_PER_FRAME; e++)
            send_beat((e % 3 == 0) ? 6'd9 : ID_W'($urandom), 1'b1, 1'b0);
    endtask

    // saturate one counter at the top, then retire everything down past zero
    task automatic test_counter_limits();
        int f;
        int e;
        drain();
        write_reg(CFG_WINDOW, 9'd32);
        write_reg(CFG_THRESHOLD, 9'd300);
        for (f = 0; f <= MAX_WINDOW; f++)
            for (e = 0; e < ((f == MAX_WINDOW) ? 1 : MAX_PER_FRAME); e++)
                send_beat(SAT_ID, 1'b1, e == 0);
        drain();
        write_reg(CFG_WINDOW, 9'd1);
        send_beat(SAT_ID, 1'b0, 1'b1);
        send_beat(SAT_ID, 1'b1, 1'b0);
    endtask

    // one setting, then random frames drawn from a small id pool
    task automatic run_phase(input logic [CFG_DATA_W-1:0] win, input logic [CFG_DATA_W-1:0] thr,
                             input int n_beats, input int pool);
        int sent;
        int k;
        logic [ID_W-1:0] id;
        drain();
        write_reg(CFG_WINDOW, win);
        write_reg(CFG_THRESHOLD, thr);
        sent = 0;
        while (sent < n_beats)
        begin
            if ($urandom_range(0, 9) == 0)
                idle_on = !idle_on;
            if ($urandom_range(0, 9) == 0)
                stall_on = !stall_on;
            send_beat(ID_W'($urandom), $urandom_range(0, 3) != 0, 1'b1);
            sent++;
            k = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 6);
            repeat (k)
            begin
                // ignored noise between detections
                if ($urandom_range(0, 7) == 0)
                    send_beat(ID_W'($urandom), 1'b0, 1'b0);
                id = ($urandom_range(0, 4) == 0) ? ID_W'($urandom)
                                                 : ID_W'($urandom_range(0, pool - 1));
                send_beat(id, 1'b1, 1'b0);
                sent++;
            end
        end
    endtask

    // settings sweep including extremes and a lowered window
    task automatic test_random_traffic();
        run_phase(9'd4, 9'd2, 200, 4);
        run_phase(9'd1, 9'd0, 150, 8);
        run_phase(9'd0, 9'd1, 100, 4);
        run_phase(9'd32, 9'd40, 250, 3);
        run_phase(9'd2, 9'd3, 150, 4);
        run_phase(9'd63, 9'd511, 150, 6);
        run_phase(9'd33, 9'd10, 100, 5);
    endtask

    // result side ready with random stalls per beat
    initial
    begin
        int stall;
        out_ready = 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            stall = stall_on ? $urandom_range(0, 9) : 0;
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // compare each result beat with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_hits.size() == 0)
            begin
                $error("unexpected result beat: id %0d count %0d", out_marker_id, hit_count);
                failures++;
            end
            else
            begin
                want = expected_hits.pop_front();
                results_checked++;
                if (confirmed)
                    confirmed_seen++;
                if (dropped)
                    dropped_seen++;
                if (out_marker_id !== want.id)
                begin
                    $error("out_marker_id: expected %0d, actual %0d", want.id, out_marker_id);
                    failures++;
                end
                if (hit_count !== want.count)
                begin
                    $error("hit_count: expected %0d, actual %0d", want.count, hit_count);
                    failures++;
                end
                if (confirmed !== want.conf)
                begin
                    $error("confirmed: expected %0d, actual %0d", want.conf, confirmed);
                    failures++;
                end
                if (dropped !== want.drop)
                begin
                    $error("dropped: expected %0d, actual %0d", want.drop, dropped);
                    failures++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("sliding_window_detection_confirm verification failed");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n       = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        marker_id   = '0;
        has_marker  = 1'b0;
        frame_start = 1'b0;
        idle_on     = 1'b1;
        stall_on    = 1'b1;
        failures        = 0;
        beats_sent      = 0;
        results_checked = 0;
        confirmed_seen  = 0;
        dropped_seen    = 0;
        foreach (hits_q[i])
            hits_q[i] = '0;
        foreach (ids_q[i])
            ids_q[i] = '0;
        foreach (fill_q[i])
            fill_q[i] = '0;
        held    = 0;
        newest  = 0;
        win_reg = WINDOW_RESET;
        thr_reg = THRESHOLD_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_before_first_frame();
        test_idle_items();
        test_frame_full();
        test_counter_limits();
        test_random_traffic();
        drain();

        $display("%0d input beats sent, %0d results checked over 10 window/threshold settings",
                 beats_sent, results_checked);
        $display("%0d confirmed and %0d dropped detections seen, %0d mismatches",
                 confirmed_seen, dropped_seen, failures);
        if (failures == 0)
            $display("sliding_window_detection_confirm verification clean");
        else
            $display("sliding_window_detection_confirm verification failed");
        $finish;
    end

endmodule
